@@ rtl/vdc_pkg.sv @@
`timescale 1ns / 1ps
package vdc_pkg;

   localparam int unsigned DutyWidth = 16;
   localparam int unsigned MoveWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   localparam logic [MoveWidth-1:0] MoveReset = MoveWidth'(30);

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] REG_OPEN_TICKS   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] REG_CLOSED_TICKS = 2'd1;
   localparam logic [CsrIndexWidth-1:0] REG_MOVE_LIMIT   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE        = 3'd0,
      PH_CONT        = 3'd1,
      PH_OPENING     = 3'd2,
      PH_CLOSING     = 3'd3,
      PH_OPEN_TIME   = 3'd4,
      PH_CLOSED_TIME = 3'd5,
      PH_DEACT       = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      ST_UNKNOWN = 2'd0,
      ST_OPEN    = 2'd1,
      ST_CLOSED  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      DRV_NONE  = 2'd0,
      DRV_OPEN  = 2'd1,
      DRV_CLOSE = 2'd2
   } drive_type;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_CONT  = 2'd1,
      CMD_DEACT = 2'd2
   } cmd_type;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_CMD  = 1'b1;

   localparam logic FAULT_NOT_OPENING = 1'b0;
   localparam logic FAULT_NOT_CLOSING = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [1:0] command;
      logic       preheating;
      logic       sensor_open;
      logic       sensor_closed;
      logic       paused;
      logic       cooking_active;
   } req_type;

   typedef struct packed {
      logic [1:0] drive;
      logic [1:0] valve_status;
      logic       fault_valid;
      logic       fault_code;
      logic [2:0] phase;
   } rsp_type;

   typedef struct packed {
      logic [DutyWidth-1:0] open_ticks;
      logic [DutyWidth-1:0] closed_ticks;
      logic [MoveWidth-1:0] move_limit;
   } cfg_type;

endpackage

@@ rtl/valve_duty_cycle_controller.sv @@
`timescale 1ns / 1ps
// a transaction accepted into the request register is stepped into the response
// register and shown on rsp; rsp stalls delay it
// throughput: one transaction per cycle while rsp is not stalled, set by the step
// logic between the request register and the response register
// reset: synchronous, active high; phase idle, status unknown, duty count 0,
// move timer and move_limit 30, open/closed tick registers 0
module valve_duty_cycle_controller (
   input  logic                              clock,
   input  logic                              reset,
   // request channel: commands and sensor ticks
   input  logic                              req_valid,
   output logic                              req_stall,
   input  vdc_pkg::req_type                  req_payload,
   // response channel: one transaction per request
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output vdc_pkg::rsp_type                  rsp_payload,
   // register write port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vdc_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [vdc_pkg::CsrDataWidth-1:0]  csr_wdata
);

   vdc_pkg::cfg_type cfg;

   // request register
   logic             in_valid_ff, in_valid_in;
   vdc_pkg::req_type in_item_ff;

   // response register
   logic             out_valid_ff, out_valid_in;
   vdc_pkg::rsp_type out_item_ff;

   vdc_pkg::rsp_type step_result;
   logic             out_free;
   logic             proc_fire;
   logic             req_fire;

   // response register can take a new result when empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the held request is stepped when its result has a place to go
   assign proc_fire = in_valid_ff && out_free;
   // request register stalls only when it holds a request that cannot move on
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   vdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // state registers update at the same edge that loads the result
   vdc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .fire   (proc_fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (proc_fire) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_payload;
      end
      if (proc_fire) begin
         out_item_ff <= step_result;
      end
   end

`ifndef SYNTH
   // a fault only comes with a drive toward a position
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.fault_valid |-> rsp_payload.drive != vdc_pkg::DRV_NONE)
      else $error("fault reported without drive");

   // fault code stays clear when no fault
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.fault_valid |->
         rsp_payload.fault_code == vdc_pkg::FAULT_NOT_OPENING)
      else $error("fault code set without fault");

   // a command transaction never drives or faults
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_item_ff.kind == vdc_pkg::KIND_CMD |=>
         out_item_ff.drive == vdc_pkg::DRV_NONE && !out_item_ff.fault_valid)
      else $error("command produced drive or fault");

   // a stepped request always lands in the response register
   assert property (@(posedge clock) disable iff (reset)
      proc_fire |=> out_valid_ff)
      else $error("result lost after step");
`endif

endmodule

@@ rtl/vdc_csr.sv @@
`timescale 1ns / 1ps
module vdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vdc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [vdc_pkg::CsrDataWidth-1:0]    csr_wdata,
   output vdc_pkg::cfg_type                    cfg
);

   vdc_pkg::cfg_type cfg_ff;
   vdc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            vdc_pkg::REG_OPEN_TICKS: begin
               cfg_in.open_ticks = csr_wdata[vdc_pkg::DutyWidth-1:0];
            end
            vdc_pkg::REG_CLOSED_TICKS: begin
               cfg_in.closed_ticks = csr_wdata[vdc_pkg::DutyWidth-1:0];
            end
            vdc_pkg::REG_MOVE_LIMIT: begin
               cfg_in.move_limit = csr_wdata[vdc_pkg::MoveWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_ticks   <= '0;
         cfg_ff.closed_ticks <= '0;
         cfg_ff.move_limit   <= vdc_pkg::MoveReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/vdc_seq.sv @@
`timescale 1ns / 1ps
module vdc_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  vdc_pkg::req_type item,
   input  vdc_pkg::cfg_type cfg,
   output vdc_pkg::rsp_type result
);

   vdc_pkg::phase_type              phase_ff, phase_in;
   vdc_pkg::status_type             status_ff, status_in;
   logic [vdc_pkg::DutyWidth-1:0]   duty_ff, duty_in;
   logic [vdc_pkg::MoveWidth-1:0]   move_ff, move_in;
   vdc_pkg::drive_type              drive;
   logic                            fault;
   logic                            code;

   always_comb begin
      phase_in  = phase_ff;
      status_in = status_ff;
      duty_in   = duty_ff;
      move_in   = move_ff;
      drive     = vdc_pkg::DRV_NONE;
      fault     = 1'b0;
      code      = vdc_pkg::FAULT_NOT_OPENING;
      if (item.kind == vdc_pkg::KIND_CMD) begin
         case (item.command)
            vdc_pkg::CMD_START: begin
               duty_in = cfg.open_ticks;
               if (!item.preheating) begin
                  phase_in = vdc_pkg::PH_OPENING;
               end
            end
            vdc_pkg::CMD_CONT: begin
               phase_in = vdc_pkg::PH_CONT;
            end
            vdc_pkg::CMD_DEACT: begin
               phase_in = vdc_pkg::PH_DEACT;
            end
            default: begin
            end
         endcase
      end else begin
         // closed switch wins when both report
         if (item.sensor_closed) begin
            status_in = vdc_pkg::ST_CLOSED;
         end else if (item.sensor_open) begin
            status_in = vdc_pkg::ST_OPEN;
         end
         if (!item.paused) begin
            case (phase_ff)
               vdc_pkg::PH_CONT, vdc_pkg::PH_OPENING: begin
                  if (status_in == vdc_pkg::ST_CLOSED) begin
                     drive = vdc_pkg::DRV_OPEN;
                     if (move_ff != '0) begin
                        move_in = move_ff - 1'b1;
                     end else begin
                        fault = 1'b1;
                        code  = vdc_pkg::FAULT_NOT_OPENING;
                     end
                  end
                  if (status_in == vdc_pkg::ST_OPEN) begin
                     move_in = cfg.move_limit;
                     if (phase_ff == vdc_pkg::PH_CONT) begin
                        phase_in = vdc_pkg::PH_IDLE;
                     end else if (item.cooking_active) begin
                        phase_in = vdc_pkg::PH_OPEN_TIME;
                     end
                  end
               end
               vdc_pkg::PH_CLOSING: begin
                  if (status_in == vdc_pkg::ST_OPEN) begin
                     drive = vdc_pkg::DRV_CLOSE;
                     if (move_ff != '0) begin
                        move_in = move_ff - 1'b1;
                     end else begin
                        fault = 1'b1;
                        code  = vdc_pkg::FAULT_NOT_CLOSING;
                     end
                  end
                  if (status_in == vdc_pkg::ST_CLOSED) begin
                     move_in = cfg.move_limit;
                     if (item.cooking_active) begin
                        phase_in = vdc_pkg::PH_CLOSED_TIME;
                     end
                  end
               end
               vdc_pkg::PH_OPEN_TIME: begin
                  if (status_in == vdc_pkg::ST_OPEN) begin
                     if (duty_ff != '0) begin
                        duty_in = duty_ff - 1'b1;
                     end else begin
                        duty_in  = cfg.closed_ticks;
                        phase_in = vdc_pkg::PH_CLOSING;
                     end
                  end
               end
               vdc_pkg::PH_CLOSED_TIME: begin
                  if (status_in == vdc_pkg::ST_CLOSED) begin
                     if (duty_ff != '0) begin
                        duty_in = duty_ff - 1'b1;
                     end else begin
                        duty_in  = cfg.open_ticks;
                        phase_in = vdc_pkg::PH_OPENING;
                     end
                  end
               end
               vdc_pkg::PH_DEACT: begin
                  drive    = vdc_pkg::DRV_CLOSE;
                  phase_in = vdc_pkg::PH_IDLE;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      result.drive        = drive;
      result.valve_status = status_in;
      result.fault_valid  = fault;
      result.fault_code   = code;
      result.phase        = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= vdc_pkg::PH_IDLE;
         status_ff <= vdc_pkg::ST_UNKNOWN;
         duty_ff   <= '0;
         move_ff   <= vdc_pkg::MoveReset;
      end else if (fire) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         duty_ff   <= duty_in;
         move_ff   <= move_in;
      end
   end

endmodule
